/* hw/rtl/srm_pkg.sv */
package srm_pkg;

	localparam int TEMP_W = 16;
	localparam int ID_W = 16;
	localparam int CFG_IDX_W = 8;

	// Item command codes
	localparam logic CMD_REGISTER = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = CFG_IDX_W'(1);

	localparam logic signed [TEMP_W-1:0] MIN_TEMP_RESET = 16'sd1500;
	localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 16'sd2500;

	typedef enum logic [2:0] {
		ST_FILLING    = 3'd0,
		ST_NORMAL     = 3'd1,
		ST_ABOVE      = 3'd2,
		ST_BELOW      = 3'd3,
		ST_UNKNOWN    = 3'd4,
		ST_REGISTERED = 3'd5,
		ST_TABLE_FULL = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REG,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_STORE,
		S_SUM,
		S_SUM_LAST,
		S_DIV_GO,
		S_DIV_WAIT
	} state_t;

	// Commands from the sequencer to the averaging unit
	typedef struct packed {
		logic clr;
		logic acc;
		logic div;
	} avg_cmd_t;

endpackage

/* hw/rtl/srm_avg_unit.sv */
module srm_avg_unit #(
	parameter int AVG_LEN = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srm_pkg::avg_cmd_t              cmd,
	input  logic signed [srm_pkg::TEMP_W-1:0] sample,
	input  logic signed [srm_pkg::TEMP_W-1:0] min_temp,
	input  logic signed [srm_pkg::TEMP_W-1:0] max_temp,
	output logic                           done,
	output logic signed [srm_pkg::TEMP_W-1:0] average,
	output srm_pkg::status_t               status
);
	import srm_pkg::*;

	localparam int LOG2 = $clog2(AVG_LEN);
	localparam int SW = TEMP_W + LOG2;
	localparam bit IS_POW2 = (AVG_LEN & (AVG_LEN - 1)) == 0;
	// Reciprocal of the window length, exact for every SW-bit magnitude
	localparam int RS = SW + LOG2;
	localparam int PW = SW + RS + 1;
	localparam logic [RS:0] RECIP =
		(RS + 1)'(((64'd1 << RS) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));
	localparam logic [SW-1:0] ROUND_UP = SW'(AVG_LEN - 1);

	logic signed [SW-1:0] acc_q;
	logic [SW-1:0] mag_q;
	logic neg_q, run_q, done_q;
	logic signed [TEMP_W-1:0] avg_q;

	logic signed [SW-1:0] sample_x;
	logic [PW-1:0] prod;
	logic [SW-1:0] quo;
	logic [SW-1:0] quo_signed;

	// Quotient of the magnitude by reciprocal multiply, sign put back
	always_comb begin
		sample_x = {{LOG2{sample[TEMP_W-1]}}, sample};
		prod = PW'(mag_q) * PW'(RECIP);
		quo = prod[RS +: SW];
		quo_signed = neg_q ? (~quo + SW'(1)) : quo;
	end

	// Window sum, then floor division by the window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			mag_q <= '0;
			neg_q <= 1'b0;
			run_q <= 1'b0;
			done_q <= 1'b0;
			avg_q <= '0;
		end else begin
			if (cmd.clr) begin
				acc_q <= '0;
			end else if (cmd.acc) begin
				acc_q <= acc_q + sample_x;
			end
			done_q <= cmd.div ? IS_POW2 : run_q;
			run_q <= cmd.div && !IS_POW2;
			if (cmd.div) begin
				// floor of a negative sum: negate, round the magnitude up
				neg_q <= acc_q[SW-1];
				mag_q <= acc_q[SW-1] ? (ROUND_UP - SW'(acc_q)) : SW'(acc_q);
			end
			if (cmd.div && IS_POW2) begin
				avg_q <= TEMP_W'(acc_q >>> LOG2);
			end else if (run_q) begin
				avg_q <= TEMP_W'(quo_signed);
			end
		end
	end

	// Threshold check: above max wins, ties are normal
	always_comb begin
		if (avg_q > max_temp) begin
			status = ST_ABOVE;
		end else if (avg_q < min_temp) begin
			status = ST_BELOW;
		end else begin
			status = ST_NORMAL;
		end
	end

	assign done = done_q;
	assign average = avg_q;

endmodule

/* hw/rtl/srm_ctrl.sv */
module srm_ctrl #(
	parameter int NUM_SENSORS = 16,
	parameter int AVG_LEN = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [srm_pkg::ID_W-1:0]          sensor_num,
	input  logic [srm_pkg::ID_W-1:0]          room_id,
	input  logic signed [srm_pkg::TEMP_W-1:0] temperature,
	output srm_pkg::avg_cmd_t                 avg_cmd,
	output logic signed [srm_pkg::TEMP_W-1:0] avg_sample,
	input  logic                              avg_done,
	input  logic signed [srm_pkg::TEMP_W-1:0] avg_value,
	input  srm_pkg::status_t                  avg_status,
	output logic                              result_valid,
	output logic [2:0]                        status,
	output logic [srm_pkg::ID_W-1:0]          sensor_ref,
	output logic [srm_pkg::ID_W-1:0]          room_ref,
	output logic signed [srm_pkg::TEMP_W-1:0] average
);
	import srm_pkg::*;

	localparam int IW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int CNTW = $clog2(NUM_SENSORS + 1);
	localparam int KW = $clog2(AVG_LEN);
	localparam int RING_DEPTH = NUM_SENSORS * (2 ** KW);
	localparam logic [KW-1:0] LAST_POS = KW'(AVG_LEN - 1);
	localparam logic [CNTW-1:0] TABLE_SIZE = CNTW'(NUM_SENSORS);

	state_t state_q, state_d;

	// Latched item
	logic cmd_q;
	logic [ID_W-1:0] sid_q, room_q;
	logic signed [TEMP_W-1:0] temp_q;

	logic [CNTW-1:0] count_q, idx_q;
	logic [KW-1:0] k_q;
	logic pend_q;

	// Entry table and sample rings
	logic [ID_W-1:0] ent_sid_mem [NUM_SENSORS];
	logic [ID_W-1:0] ent_room_mem [NUM_SENSORS];
	logic [KW-1:0] ent_pos_mem [NUM_SENSORS];
	logic ent_full_mem [NUM_SENSORS];
	logic signed [TEMP_W-1:0] ring_mem [RING_DEPTH];

	logic [ID_W-1:0] ent_sid_q, ent_room_q;
	logic [KW-1:0] ent_pos_q;
	logic ent_full_q;
	logic signed [TEMP_W-1:0] ring_rd_q;

	logic res_valid_q;
	status_t status_q;
	logic [ID_W-1:0] sref_q, rref_q;
	logic signed [TEMP_W-1:0] avg_q;

	// Control decoded per state
	logic ent_we, ring_we, full_new, hit, exhausted;
	logic [IW-1:0] ent_waddr;
	logic [ID_W-1:0] ent_wsid, ent_wroom;
	logic [KW-1:0] pos_new;
	logic res_set;
	status_t res_status;
	logic [ID_W-1:0] res_room;
	logic signed [TEMP_W-1:0] res_avg;

	always_comb begin
		exhausted = idx_q >= count_q;
		hit = ent_sid_q == sid_q;
		full_new = ent_full_q | (ent_pos_q == LAST_POS);
		pos_new = (ent_pos_q == LAST_POS) ? '0 : ent_pos_q + KW'(1);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (cmd == CMD_SAMPLE) ? S_SCAN_RD : S_REG;
				end
			end
			S_REG: state_d = S_IDLE;
			S_SCAN_RD: state_d = exhausted ? S_IDLE : S_SCAN_CMP;
			S_SCAN_CMP: state_d = hit ? S_STORE : S_SCAN_RD;
			S_STORE: state_d = full_new ? S_SUM : S_IDLE;
			S_SUM: state_d = (k_q == LAST_POS) ? S_SUM_LAST : S_SUM;
			S_SUM_LAST: state_d = S_DIV_GO;
			S_DIV_GO: state_d = S_DIV_WAIT;
			S_DIV_WAIT: state_d = avg_done ? S_IDLE : S_DIV_WAIT;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs per state
	always_comb begin
		ent_we = 1'b0;
		ring_we = 1'b0;
		ent_waddr = idx_q[IW-1:0];
		ent_wsid = ent_sid_q;
		ent_wroom = ent_room_q;
		res_set = 1'b0;
		res_status = ST_UNKNOWN;
		res_room = '0;
		res_avg = '0;
		avg_cmd = '0;
		case (state_q)
			S_REG: begin
				res_set = 1'b1;
				if (count_q == TABLE_SIZE) begin
					res_status = ST_TABLE_FULL;
				end else begin
					ent_we = 1'b1;
					ent_waddr = count_q[IW-1:0];
					ent_wsid = sid_q;
					ent_wroom = room_q;
					res_status = ST_REGISTERED;
					res_room = room_q;
				end
			end
			S_SCAN_RD: begin
				res_set = exhausted;
			end
			S_STORE: begin
				ent_we = 1'b1;
				ring_we = 1'b1;
				res_set = !full_new;
				res_status = ST_FILLING;
				res_room = ent_room_q;
				avg_cmd.clr = full_new;
			end
			S_SUM_LAST: begin
				avg_cmd.acc = pend_q;
			end
			S_SUM: begin
				avg_cmd.acc = pend_q;
			end
			S_DIV_GO: begin
				avg_cmd.div = 1'b1;
			end
			S_DIV_WAIT: begin
				res_set = avg_done;
				res_status = avg_status;
				res_room = room_q;
				res_avg = avg_value;
			end
			default: begin
			end
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_valid_q <= res_set;
			pend_q <= state_q == S_SUM;
			if (state_q == S_IDLE) begin
				idx_q <= '0;
			end else if (state_q == S_SCAN_CMP && !hit) begin
				idx_q <= idx_q + CNTW'(1);
			end
			if (state_q == S_SUM) begin
				k_q <= k_q + KW'(1);
			end else begin
				k_q <= '0;
			end
			if (state_q == S_REG && count_q != TABLE_SIZE) begin
				count_q <= count_q + CNTW'(1);
			end
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			sid_q <= sensor_num;
			room_q <= room_id;
			temp_q <= temperature;
		end else if (state_q == S_STORE) begin
			room_q <= ent_room_q;
		end
		if (res_set) begin
			status_q <= res_status;
			sref_q <= sid_q;
			rref_q <= res_room;
			avg_q <= res_avg;
		end
	end

	// Entry table: one write port, registered read at the scan index
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_sid_mem[ent_waddr] <= ent_wsid;
			ent_room_mem[ent_waddr] <= ent_wroom;
			ent_pos_mem[ent_waddr] <= (state_q == S_STORE) ? pos_new : '0;
			ent_full_mem[ent_waddr] <= (state_q == S_STORE) ? full_new : 1'b0;
		end
		ent_sid_q <= ent_sid_mem[idx_q[IW-1:0]];
		ent_room_q <= ent_room_mem[idx_q[IW-1:0]];
		ent_pos_q <= ent_pos_mem[idx_q[IW-1:0]];
		ent_full_q <= ent_full_mem[idx_q[IW-1:0]];
	end

	// Sample rings: write the new sample, read the window back in order
	always_ff @(posedge clk) begin
		if (ring_we && cmd_q == CMD_SAMPLE) begin
			ring_mem[{idx_q[IW-1:0], ent_pos_q}] <= temp_q;
		end
		ring_rd_q <= ring_mem[{idx_q[IW-1:0], k_q}];
	end

	assign busy = state_q != S_IDLE;
	assign avg_sample = ring_rd_q;
	assign result_valid = res_valid_q;
	assign status = status_q;
	assign sensor_ref = sref_q;
	assign room_ref = rref_q;
	assign average = avg_q;

endmodule

/* hw/rtl/sensor_running_average_monitor_top.sv */
// Register item: the result strobe follows the S_REG state. A sample item with an unknown id
// scans every entry; a known id scans up to its entry. Once its window is full, the samples are
// summed, divided (by reciprocal multiply unless AVG_LEN is a power of two) and checked.
// One item at a time; busy is high until the strobe cycle, and start is taken only while idle.
// The receiver cannot stall: result_valid pulses for one cycle per item.
// Reset (arst_n low) empties the sensor table and restores thresholds 1500 and 2500.
module sensor_running_average_monitor_top #(
	parameter int NUM_SENSORS = 16,
	parameter int AVG_LEN = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 cmd,
	input  logic [srm_pkg::ID_W-1:0]             sensor_num,
	input  logic [srm_pkg::ID_W-1:0]             room_id,
	input  logic signed [srm_pkg::TEMP_W-1:0]    temperature,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [srm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [srm_pkg::TEMP_W-1:0]           cfg_data,
	output logic                                 result_valid,
	output logic [2:0]                           status,
	output logic [srm_pkg::ID_W-1:0]             sensor_ref,
	output logic [srm_pkg::ID_W-1:0]             room_ref,
	output logic signed [srm_pkg::TEMP_W-1:0]    average
);
	import srm_pkg::*;

	logic signed [TEMP_W-1:0] min_temp_q, max_temp_q;
	avg_cmd_t avg_cmd;
	logic signed [TEMP_W-1:0] avg_sample, avg_value;
	logic avg_done;
	status_t avg_status;

	// Threshold registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q <= MIN_TEMP_RESET;
			max_temp_q <= MAX_TEMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_TEMP: min_temp_q <= cfg_data;
				REG_MAX_TEMP: max_temp_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	srm_ctrl #(
		.NUM_SENSORS(NUM_SENSORS),
		.AVG_LEN(AVG_LEN)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.sensor_num(sensor_num),
		.room_id(room_id),
		.temperature(temperature),
		.avg_cmd(avg_cmd),
		.avg_sample(avg_sample),
		.avg_done(avg_done),
		.avg_value(avg_value),
		.avg_status(avg_status),
		.result_valid(result_valid),
		.status(status),
		.sensor_ref(sensor_ref),
		.room_ref(room_ref),
		.average(average)
	);

	srm_avg_unit #(
		.AVG_LEN(AVG_LEN)
	) u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(avg_cmd),
		.sample(avg_sample),
		.min_temp(min_temp_q),
		.max_temp(max_temp_q),
		.done(avg_done),
		.average(avg_value),
		.status(avg_status)
	);

endmodule
